### hdl/premultiplied_bgra_over_blend_assert.svh
// Assertion macros shared by the blend pipeline.
`ifndef PREMULTIPLIED_BGRA_OVER_BLEND_ASSERT_SVH
`define PREMULTIPLIED_BGRA_OVER_BLEND_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PBOB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pbob assertion failed");
// Checked at every edge, reset included.
`define PBOB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pbob assertion failed");
`else
`define PBOB_ASSERT(lbl, clk, rstn, prop)
`define PBOB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/pbob_pkg.sv
package pbob_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int NUM_LANES      = 4;
  localparam int CHAN_BITS      = 8;
  localparam int PIX_BITS       = NUM_LANES * CHAN_BITS;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CHAN_BITS-1:0] CHAN_MAX   = 8'd255;
  localparam logic [16:0]          ROUND_BIAS = 17'd127;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 3'd5;

endpackage

### hdl/pbob_if.sv
interface pbob_in_if #(
  parameter int COORD_BITS = pbob_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         pix_x;
  logic [COORD_BITS-1:0]         pix_y;
  logic [pbob_pkg::PIX_BITS-1:0] dst_pixel;
  logic [pbob_pkg::PIX_BITS-1:0] src_pixel;

  modport source (output valid, pix_x, pix_y, dst_pixel, src_pixel, input ready);
  modport sink   (input valid, pix_x, pix_y, dst_pixel, src_pixel, output ready);
endinterface

interface pbob_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbob_pkg::PIX_BITS-1:0] result_pixel;
  logic                          covered;

  modport source (output valid, result_pixel, covered, input ready);
  modport sink   (input valid, result_pixel, covered, output ready);
endinterface

### hdl/pbob_hit.sv
module pbob_hit #(
  parameter int COORD_BITS = pbob_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] pix_x_i,
  input  logic [COORD_BITS-1:0] pix_y_i,
  input  logic [COORD_BITS-1:0] origin_x_i,
  input  logic [COORD_BITS-1:0] origin_y_i,
  input  logic [COORD_BITS:0]   src_width_i,
  input  logic [COORD_BITS:0]   src_height_i,
  input  logic [COORD_BITS:0]   dst_width_i,
  input  logic [COORD_BITS:0]   dst_height_i,
  output logic                  hit_o
);
  import pbob_pkg::*;

  logic [COORD_BITS:0] dx;
  logic [COORD_BITS:0] dy;
  logic                hit_x;
  logic                hit_y;

  // With the origin inside the destination, p < org + min(ssz, dsz - org)
  // is the same as (p - org) < ssz together with p < dsz.
  assign dx = {1'b0, pix_x_i} - {1'b0, origin_x_i};
  assign dy = {1'b0, pix_y_i} - {1'b0, origin_y_i};

  assign hit_x = ({1'b0, origin_x_i} < dst_width_i) && (pix_x_i >= origin_x_i) &&
                 (dx < src_width_i) && ({1'b0, pix_x_i} < dst_width_i);
  assign hit_y = ({1'b0, origin_y_i} < dst_height_i) && (pix_y_i >= origin_y_i) &&
                 (dy < src_height_i) && ({1'b0, pix_y_i} < dst_height_i);

  assign hit_o = hit_x && hit_y;
endmodule

### hdl/pbob_lane.sv
module pbob_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pbob_pkg::CHAN_BITS-1:0] src_i,
  input  logic [pbob_pkg::CHAN_BITS-1:0] dst_i,
  input  logic [pbob_pkg::CHAN_BITS-1:0] alpha_i,
  output logic [pbob_pkg::CHAN_BITS-1:0] chan_o
);
  import pbob_pkg::*;

  logic [2*CHAN_BITS-1:0] prod_d, prod_q;
  logic [CHAN_BITS-1:0]   src_q;
  logic [16:0]            biased;
  logic [16:0]            quot_pre;
  logic [8:0]             scaled;
  logic [9:0]             sum;

  assign prod_d = dst_i * (CHAN_MAX - alpha_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      src_q  <= src_i;
    end
  end

  // Division by 255, rounded to nearest, for products up to 255*255.
  assign biased   = {1'b0, prod_q} + ROUND_BIAS;
  assign quot_pre = biased + (biased >> 8) + 17'd1;
  assign scaled   = quot_pre[16:8];
  assign sum      = {2'b00, src_q} + {1'b0, scaled};
  assign chan_o   = (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[CHAN_BITS-1:0];
endmodule

### hdl/premultiplied_bgra_over_blend.sv
// Channel   Direction  Handshake      Contents
// in_if     sink       valid/ready    pix_x, pix_y, dst_pixel, src_pixel
// out_if    source     valid/ready    result_pixel, covered
// cfg       write      cfg_we_i       cfg_idx_i selects register, cfg_data_i
//
// One pixel per clock unless the output stalls.
// The four channel lanes each register one 8x8 product; the second stage
// divides by 255, adds the source and saturates into the output register.
// A stalled output holds both stages; input ready follows output ready.
// Reset clears valid flags and configuration registers to zero.
module premultiplied_bgra_over_blend #(
  parameter int COORD_BITS = pbob_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pbob_in_if.sink                           in_if,
  pbob_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [pbob_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS:0]               cfg_data_i
);
  import pbob_pkg::*;

  `include "premultiplied_bgra_over_blend_assert.svh"

  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [COORD_BITS:0]   src_width_q, src_height_q, dst_width_q, dst_height_q;

  logic                adv;
  logic                hit;
  logic                s1_valid_q, s1_hit_q;
  logic [PIX_BITS-1:0] s1_dst_q;
  logic                out_valid_q, out_cov_q;
  logic [PIX_BITS-1:0] out_pix_q, out_pix_d;
  logic [PIX_BITS-1:0] blended;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      src_width_q  <= '0;
      src_height_q <= '0;
      dst_width_q  <= '0;
      dst_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i[COORD_BITS-1:0];
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i[COORD_BITS-1:0];
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        REG_DST_WIDTH:  dst_width_q  <= cfg_data_i;
        REG_DST_HEIGHT: dst_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pbob_hit #(.COORD_BITS(COORD_BITS)) u_hit (
    .pix_x_i      (in_if.pix_x),
    .pix_y_i      (in_if.pix_y),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .dst_width_i  (dst_width_q),
    .dst_height_i (dst_height_q),
    .hit_o        (hit)
  );

  // Both stages move together whenever the output register can take a value.
  assign adv         = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pbob_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .src_i   (in_if.src_pixel[g*CHAN_BITS +: CHAN_BITS]),
      .dst_i   (in_if.dst_pixel[g*CHAN_BITS +: CHAN_BITS]),
      .alpha_i (in_if.src_pixel[PIX_BITS-1 -: CHAN_BITS]),
      .chan_o  (blended[g*CHAN_BITS +: CHAN_BITS])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_if.valid;
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_pix_d = s1_hit_q ? blended : s1_dst_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hit_q  <= hit;
      s1_dst_q  <= in_if.dst_pixel;
      out_cov_q <= s1_hit_q;
      out_pix_q <= out_pix_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.result_pixel = out_pix_q;
  assign out_if.covered      = out_cov_q;

  `PBOB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni ##1 !rst_ni |=> !s1_valid_q && !out_valid_q)
  `PBOB_ASSERT(a_accept_fills, clk_i, rst_ni, in_if.valid && in_if.ready |=> s1_valid_q)
  `PBOB_ASSERT(a_stall_holds, clk_i, rst_ni, s1_valid_q && !adv |=> s1_valid_q && $stable(s1_dst_q))
  `PBOB_ASSERT(a_pass_through, clk_i, rst_ni,
               adv && s1_valid_q && !s1_hit_q |=> out_pix_q == $past(s1_dst_q) && !out_cov_q)
endmodule
